[rtl/rqps_pkg.sv]
// Shared types and constants for the ready-queue scheduler.
// No dependencies.
`timescale 1ns / 1ps
package rqps_pkg;
    localparam logic [1:0] POL_PRIO = 2'd0;
    localparam logic [1:0] POL_SRTF = 2'd1;
    localparam logic [1:0] POL_RR   = 2'd2;
    localparam logic       CMD_ARRIVE = 1'b0;
    localparam logic       CMD_DONE   = 1'b1;
    localparam logic       CFG_POLICY  = 1'b0;
    localparam logic       CFG_QUANTUM = 1'b1;
    localparam logic [23:0] TIME_MAX = 24'hFFFFFF;
    localparam logic [15:0] BURST_MAX = 16'hFFFF;

    typedef struct packed {
        logic [15:0] id;
        logic [23:0] arrival;
        logic [15:0] total;
        logic [15:0] remaining;
        logic [7:0]  prio;
    } proc_t;
endpackage

[rtl/rqps_cell.sv]
// One ready-queue slot: holds an entry, loads it, or takes its right neighbor's.
// Depends on rqps_pkg.
`timescale 1ns / 1ps
module rqps_cell (
    input  logic           aclk,
    input  logic           load,
    input  logic           shift,
    input  rqps_pkg::proc_t load_rec,
    input  rqps_pkg::proc_t right_rec,
    output rqps_pkg::proc_t rec
);
    import rqps_pkg::*;
    proc_t rec_reg;
    always_ff @(posedge aclk) begin
        if (load) begin
            rec_reg <= load_rec;
        end else if (shift) begin
            rec_reg <= right_rec;
        end
    end
    assign rec = rec_reg;
endmodule

[rtl/ready_queue_process_scheduler_core.sv]
// Ready-queue scheduler top level: chain of queue cells plus control.
// Depends on rqps_pkg and rqps_cell.
`timescale 1ns / 1ps
// Usage:
//   s_axis carries one command word; m_axis returns the running record.
//   Config writes (cfg_we/cfg_index/cfg_wdata) only while idle.
//   An arrival's result passes through emit_reg into the output register.
//   A completion walks the queue one cell a cycle to find the best entry,
//   then closes the gap by shifting the cells right of it one place left
//   all at once.
//   One command is in flight at a time; s_axis_tready is low while busy,
//   while a result is being formed or while it waits in the output register.
//   Reset (aresetn low, synchronous) empties the queue, clears the running
//   record and loads policy 0, quantum 1.
//   A stalled m_axis holds its word; no new command is taken until it goes.
//   s_axis_tdata: cmd[0], timestamp[24:1], proc_id[40:25], arrival_time[64:41],
//   total_burst[80:65], prio[88:81], zero fill to 96 bits.
module ready_queue_process_scheduler_core #(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // cmd, timestamp, proc_id, arrival_time, total_burst, prio (low to high)
    input  logic [95:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // run_valid, run_proc_id, run_arrival, run_total, run_start, run_end,
    // run_remaining, run_prio, queued, dropped (low to high)
    output logic [135:0] m_axis_tdata,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [15:0] cfg_wdata
);
    import rqps_pkg::*;
    localparam int IW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    logic [1:0]  state_reg;
    logic [1:0]  policy_reg;
    logic [15:0] quantum_reg;
    logic [CW-1:0] count_reg;
    logic        running_reg;
    proc_t       run_reg;
    logic [23:0] start_reg, end_reg;
    logic [23:0] ts_reg;
    logic [CW-1:0] scan_reg;
    logic [IW-1:0] best_reg;
    logic [23:0] best_key_reg;
    logic        out_valid_reg;
    logic [135:0] out_reg;
    logic        drop_reg;

    proc_t cell_rec [QUEUE_DEPTH];
    proc_t cell_in [QUEUE_DEPTH];
    logic [QUEUE_DEPTH-1:0] cell_load, cell_shift;
    proc_t enq_rec;
    logic  enq_do;
    logic  do_shift;

    genvar g;
    generate
        for (g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
            if (g == QUEUE_DEPTH - 1) begin : g_last
                assign cell_in[g] = cell_rec[g];
            end else begin : g_mid
                assign cell_in[g] = cell_rec[g+1];
            end
            assign cell_load[g] = enq_do && (count_reg == CW'(g));
            assign cell_shift[g] = do_shift && (CW'(g) >= CW'(best_reg));
            rqps_cell u_cell (
                .aclk(aclk), .load(cell_load[g]), .shift(cell_shift[g]),
                .load_rec(enq_rec), .right_rec(cell_in[g]), .rec(cell_rec[g])
            );
        end
    endgenerate

    // input fields
    logic        in_cmd;
    logic [23:0] in_ts;
    proc_t       np;
    assign in_cmd = s_axis_tdata[0];
    assign in_ts  = s_axis_tdata[24:1];
    assign np.id = s_axis_tdata[40:25];
    assign np.arrival = s_axis_tdata[64:41];
    assign np.total = s_axis_tdata[80:65];
    assign np.remaining = s_axis_tdata[80:65];
    assign np.prio = s_axis_tdata[88:81];

    logic emit_reg;
    logic accept;
    assign s_axis_tready = (state_reg == ST_IDLE) && !out_valid_reg && !emit_reg;
    assign accept = s_axis_tvalid && s_axis_tready;

    // live remaining of running process
    logic [15:0] live_rem;
    logic [23:0] diff;
    assign diff = end_reg - in_ts;
    assign live_rem = (in_ts >= end_reg) ? 16'd0 :
                      ((diff > 24'(BURST_MAX)) ? BURST_MAX : diff[15:0]);

    logic preempt;
    always_comb begin
        case (policy_reg)
            POL_PRIO: preempt = np.prio < run_reg.prio;
            POL_SRTF: preempt = !(live_rem < np.total);
            default:  preempt = 1'b0;
        endcase
    end

    logic full;
    assign full = count_reg >= CW'(QUEUE_DEPTH);

    // start-process helper inputs
    proc_t       st_rec;
    logic [23:0] st_ts;
    logic [15:0] st_len;
    logic [24:0] st_sum;
    always_comb begin
        st_len = st_rec.remaining;
        if (policy_reg >= POL_RR && quantum_reg < st_len) begin
            st_len = quantum_reg;
        end
        st_sum = {1'b0, st_ts} + 25'(st_len);
    end

    proc_t old_rec;
    always_comb begin
        old_rec = run_reg;
        old_rec.remaining = live_rem;
    end

    logic arr_path;
    assign arr_path = accept && (in_cmd == CMD_ARRIVE);
    assign enq_do = arr_path && running_reg && !full;
    assign enq_rec = preempt ? old_rec : np;
    assign do_shift = (state_reg == ST_DONE);

    logic [23:0] key;
    proc_t scan_rec;
    assign scan_rec = cell_rec[scan_reg[IW-1:0]];
    always_comb begin
        case (policy_reg)
            POL_PRIO: key = 24'(scan_rec.prio);
            POL_SRTF: key = 24'(scan_rec.remaining);
            default:  key = scan_rec.arrival;
        endcase
    end

    logic start_now;
    always_comb begin
        st_rec = np;
        st_ts = in_ts;
        start_now = 1'b0;
        if (arr_path && (!running_reg || preempt)) begin
            start_now = 1'b1;
        end
        if (do_shift) begin
            st_rec = cell_rec[best_reg];
            st_ts = ts_reg;
            start_now = 1'b1;
        end
    end

    logic [135:0] res;
    always_comb begin
        res = '0;
        res[0] = running_reg;
        if (running_reg) begin
            res[16:1] = run_reg.id;
            res[40:17] = run_reg.arrival;
            res[56:41] = run_reg.total;
            res[80:57] = start_reg;
            res[104:81] = end_reg;
            res[120:105] = run_reg.remaining;
            res[128:121] = run_reg.prio;
        end
        res[133:129] = 5'(count_reg);
        res[134] = drop_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            policy_reg <= POL_PRIO;
            quantum_reg <= 16'd1;
            count_reg <= '0;
            running_reg <= 1'b0;
            run_reg <= '0;
            start_reg <= '0;
            end_reg <= '0;
            out_valid_reg <= 1'b0;
            emit_reg <= 1'b0;
            drop_reg <= 1'b0;
        end else begin
            emit_reg <= 1'b0;
            if (cfg_we) begin
                if (cfg_index == CFG_QUANTUM) quantum_reg <= cfg_wdata;
                else policy_reg <= cfg_wdata[1:0];
            end
            if (emit_reg) begin
                out_valid_reg <= 1'b1;
                out_reg <= res;
            end else if (out_valid_reg && m_axis_tready) begin
                out_valid_reg <= 1'b0;
            end
            if (start_now) begin
                run_reg <= st_rec;
                start_reg <= st_ts;
                end_reg <= st_sum[24] ? TIME_MAX : st_sum[23:0];
                running_reg <= 1'b1;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (accept) begin
                        ts_reg <= in_ts;
                        drop_reg <= arr_path && running_reg && full;
                        if (arr_path) begin
                            if (enq_do) count_reg <= count_reg + 1'b1;
                            emit_reg <= 1'b1;
                        end else if (count_reg == '0) begin
                            running_reg <= 1'b0;
                            run_reg <= '0;
                            start_reg <= '0;
                            end_reg <= '0;
                            emit_reg <= 1'b1;
                        end else begin
                            scan_reg <= '0;
                            best_reg <= '0;
                            best_key_reg <= '1;
                            state_reg <= ST_SCAN;
                        end
                    end
                end
                ST_SCAN: begin
                    // strict less keeps the lowest position on ties
                    if (scan_reg == '0 || key < best_key_reg) begin
                        best_reg <= scan_reg[IW-1:0];
                        best_key_reg <= key;
                    end
                    if (scan_reg == count_reg - 1'b1) state_reg <= ST_DONE;
                    else scan_reg <= scan_reg + 1'b1;
                end
                ST_DONE: begin
                    count_reg <= count_reg - 1'b1;
                    emit_reg <= 1'b1;
                    state_reg <= ST_IDLE;
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata = out_reg;

    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(QUEUE_DEPTH)) else $error("queue count overflow");
    a_ready_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg != ST_IDLE |-> !s_axis_tready) else $error("ready while busy");
    a_scan_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_SCAN |-> scan_reg < count_reg) else $error("scan past count");
endmodule
